// ===== rtl/hevc_sps_picture_size_parser_defines.svh =====
// Assertion macros for the SPS picture-size parser.
`ifndef HEVC_SPS_PICTURE_SIZE_PARSER_DEFINES_SVH
`define HEVC_SPS_PICTURE_SIZE_PARSER_DEFINES_SVH

`ifndef SYNTH

`define HSPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HSPS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`else

`define HSPS_ASSERT(label, clk, rst_n, prop, msg)

`define HSPS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/hsps_pkg.sv =====
// Types, codes and syntax lengths for the SPS picture-size parser.
package hsps_pkg;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SHIFT,
    CS_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    SX_VPS,
    SX_MAXSUB,
    SX_NEST,
    SX_GEN,
    SX_SUBFLAGS,
    SX_SUBPROF,
    SX_SUBLEVEL,
    SX_SEQID,
    SX_CHROMA,
    SX_SEPPLANE,
    SX_WIDTH,
    SX_HEIGHT,
    SX_DONE
  } syntax_step_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOT_SPS = 3'd1;
  localparam logic [2:0] ST_EARLY   = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_LARGE   = 3'd4;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h7e;
  localparam logic [7:0] NAL_TYPE_SPS  = 8'h42;
  localparam logic [7:0] EPB_BYTE      = 8'h03;

  localparam logic [6:0] LEN_VPS      = 7'd4;
  localparam logic [6:0] LEN_MAXSUB   = 7'd3;
  localparam logic [6:0] LEN_NEST     = 7'd1;
  localparam logic [6:0] LEN_GEN      = 7'd96;
  localparam logic [6:0] LEN_SUBFLAGS = 7'd16;
  localparam logic [6:0] LEN_SUBPROF  = 7'd88;
  localparam logic [6:0] LEN_SUBLEVEL = 7'd8;
  localparam logic [6:0] LEN_SEPPLANE = 7'd1;

  localparam logic [5:0] GOLOMB_MAX_ZEROS = 6'd32;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
    logic       prof;
  } sl_pick_t;

  function automatic sl_pick_t pick_sub_layer(logic [3:0] start, logic [2:0] count,
                                              logic [15:0] flags);
    sl_pick_t res;
    res = '0;
    for (int i = 7; i >= 0; i--) begin
      if ((4'(i) >= start) && (3'(i) < count) && (flags[15 - 2 * i] || flags[14 - 2 * i]))
      begin
        res.found = 1'b1;
        res.idx   = 3'(i);
        res.prof  = flags[15 - 2 * i];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/hevc_sps_picture_size_parser.sv =====
// SPS picture-size parser: bit-serial walk of one SPS NAL unit to width and height.
//
//   channel | dir | ports                                        | moves
//   in      | in  | in_valid in_ready in_data_byte in_last_byte  | one NAL byte per request
//   out     | out | out_valid out_ready out_status out_luma_*    | one result per NAL unit
//
// Header bytes and the 03 of a 00 00 03 are only accepted; a payload byte is accepted,
// then shifted in 8 bit steps through the byte shift register, one syntax bit per cycle.
// After the last byte a finish state loads the result register; it waits there while a
// previous result is still held. rst_n is synchronous and clears all parse state but
// the shift register. in_ready is high only while the bit shifter is idle.
`include "hevc_sps_picture_size_parser_defines.svh"

module hevc_sps_picture_size_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_luma_width,
  output logic [15:0] out_luma_height
);
  import hsps_pkg::*;

  ctrl_state_t  state_r, state_nxt;
  syntax_step_t step_r, step_nxt;

  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [6:0]  field_cnt_r, field_cnt_nxt;
  logic [2:0]  sub_count_r, sub_count_nxt;
  logic [15:0] sub_flags_r, sub_flags_nxt;
  logic [2:0]  sub_idx_r, sub_idx_nxt;
  logic [5:0]  g_zeros_r, g_zeros_nxt;
  logic [32:0] g_value_r, g_value_nxt;
  logic [1:0]  chroma_r, chroma_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [2:0]  error_r, error_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_width_r, out_width_nxt;
  logic [15:0] out_height_r, out_height_nxt;

  logic        b;
  logic [1:0]  next_run;
  logic [6:0]  fb_inc;
  logic [6:0]  fix_len;
  logic        fix_done;
  logic [3:0]  pick_start;
  logic [15:0] pick_flags;
  sl_pick_t    pick;
  logic [3:0]  lf_pos;
  logic        g_in_prefix;
  logic [5:0]  g_zeros_inc;
  logic [5:0]  g_zeros_dec;
  logic [32:0] g_shift;
  logic [32:0] g_fin_val;
  logic        g_big;
  logic        g_chroma_big;
  logic [15:0] g_v16;
  logic [1:0]  chroma_new;
  logic        g_fin;
  logic [2:0]  status_now;

  assign in_ready        = (state_r == CS_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_luma_width  = out_width_r;
  assign out_luma_height = out_height_r;

  always_comb begin
    b           = shift_r[7];
    next_run    = (in_data_byte == 8'd0) ? ((zero_run_r < 2'd2) ? zero_run_r + 2'd1 : 2'd2)
                                         : 2'd0;
    fb_inc      = field_cnt_r + 7'd1;
    case (step_r)
      SX_VPS:      fix_len = LEN_VPS;
      SX_MAXSUB:   fix_len = LEN_MAXSUB;
      SX_NEST:     fix_len = LEN_NEST;
      SX_GEN:      fix_len = LEN_GEN;
      SX_SUBFLAGS: fix_len = LEN_SUBFLAGS;
      SX_SUBPROF:  fix_len = LEN_SUBPROF;
      SX_SUBLEVEL: fix_len = LEN_SUBLEVEL;
      SX_SEPPLANE: fix_len = LEN_SEPPLANE;
      default:     fix_len = LEN_NEST;
    endcase
    fix_done    = (fb_inc >= fix_len);
    if (step_r == SX_SUBFLAGS) begin
      pick_start = 4'd0;
      pick_flags = {sub_flags_r[14:0], b};
    end else begin
      pick_start = {1'b0, sub_idx_r} + 4'd1;
      pick_flags = sub_flags_r;
    end
    pick        = pick_sub_layer(pick_start, sub_count_r, pick_flags);
    lf_pos      = 4'd14 - {sub_idx_r, 1'b0};
    g_in_prefix = (g_value_r == 33'd0);
    g_zeros_inc = g_zeros_r + 6'd1;
    g_zeros_dec = g_zeros_r - 6'd1;
    g_shift     = {g_value_r[31:0], b};
    g_fin_val   = g_in_prefix ? 33'd1 : g_shift;
    g_big       = (|g_fin_val[32:17]) || (g_fin_val[16] && (|g_fin_val[15:0]));
    g_chroma_big = (|g_fin_val[32:3]) || (g_fin_val[2] && (|g_fin_val[1:0]));
    g_v16       = g_fin_val[15:0] - 16'd1;
    chroma_new  = g_chroma_big ? 2'd0 : g_v16[1:0];
    g_fin       = 1'b0;
    status_now  = error_r;
    if (error_r == ST_OK && step_r != SX_DONE) begin
      status_now = ST_EARLY;
    end

    state_nxt      = state_r;
    step_nxt       = step_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    last_nxt       = last_r;
    byte_index_nxt = byte_index_r;
    zero_run_nxt   = zero_run_r;
    field_cnt_nxt  = field_cnt_r;
    sub_count_nxt  = sub_count_r;
    sub_flags_nxt  = sub_flags_r;
    sub_idx_nxt    = sub_idx_r;
    g_zeros_nxt    = g_zeros_r;
    g_value_nxt    = g_value_r;
    chroma_nxt     = chroma_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    error_nxt      = error_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_width_nxt  = out_width_r;
    out_height_nxt = out_height_r;

    case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          last_nxt  = in_last_byte;
          state_nxt = in_last_byte ? CS_FINISH : CS_IDLE;
          if (byte_index_r == 2'd0) begin
            if ((in_data_byte & NAL_TYPE_MASK) != NAL_TYPE_SPS) begin
              if (error_r == ST_OK) error_nxt = ST_NOT_SPS;
              step_nxt = SX_DONE;
            end
            byte_index_nxt = 2'd1;
            zero_run_nxt   = next_run;
          end else if (byte_index_r == 2'd1) begin
            byte_index_nxt = 2'd2;
            zero_run_nxt   = next_run;
          end else if (zero_run_r >= 2'd2 && in_data_byte == EPB_BYTE) begin
            zero_run_nxt = 2'd0;
          end else begin
            zero_run_nxt = next_run;
            shift_nxt    = in_data_byte;
            bit_cnt_nxt  = 3'd0;
            state_nxt    = CS_SHIFT;
          end
        end
      end
      CS_SHIFT: begin
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = last_r ? CS_FINISH : CS_IDLE;
        end
        case (step_r)
          SX_VPS: begin
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) step_nxt = SX_MAXSUB;
          end
          SX_MAXSUB: begin
            sub_count_nxt = {sub_count_r[1:0], b};
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) step_nxt = SX_NEST;
          end
          SX_NEST: begin
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) step_nxt = SX_GEN;
          end
          SX_GEN: begin
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) step_nxt = (sub_count_r != 3'd0) ? SX_SUBFLAGS : SX_SEQID;
          end
          SX_SUBFLAGS, SX_SUBLEVEL: begin
            if (step_r == SX_SUBFLAGS) sub_flags_nxt = pick_flags;
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) begin
              if (pick.found) begin
                sub_idx_nxt = pick.idx;
                step_nxt    = pick.prof ? SX_SUBPROF : SX_SUBLEVEL;
              end else begin
                step_nxt = SX_SEQID;
              end
            end
          end
          SX_SUBPROF: begin
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) begin
              if (sub_flags_r[lf_pos]) begin
                step_nxt = SX_SUBLEVEL;
              end else if (pick.found) begin
                sub_idx_nxt = pick.idx;
                step_nxt    = pick.prof ? SX_SUBPROF : SX_SUBLEVEL;
              end else begin
                step_nxt = SX_SEQID;
              end
            end
          end
          SX_SEPPLANE: begin
            field_cnt_nxt = fix_done ? 7'd0 : fb_inc;
            if (fix_done) step_nxt = SX_WIDTH;
          end
          SX_SEQID, SX_CHROMA, SX_WIDTH, SX_HEIGHT: begin
            if (g_in_prefix) begin
              if (!b) begin
                g_zeros_nxt = g_zeros_inc;
                if (g_zeros_inc > GOLOMB_MAX_ZEROS) begin
                  g_zeros_nxt = 6'd0;
                  if (error_r == ST_OK) error_nxt = ST_LARGE;
                  step_nxt = SX_DONE;
                end
              end else begin
                g_value_nxt = 33'd1;
                g_fin       = (g_zeros_r == 6'd0);
              end
            end else begin
              g_value_nxt = g_shift;
              g_zeros_nxt = g_zeros_dec;
              g_fin       = (g_zeros_dec == 6'd0);
            end
          end
          default: begin
          end
        endcase
        if (g_fin) begin
          g_zeros_nxt = 6'd0;
          g_value_nxt = 33'd0;
          case (step_r)
            SX_SEQID: step_nxt = SX_CHROMA;
            SX_CHROMA: begin
              chroma_nxt = chroma_new;
              step_nxt   = (chroma_new == 2'd3) ? SX_SEPPLANE : SX_WIDTH;
            end
            SX_WIDTH: begin
              if (g_big) begin
                if (error_r == ST_OK) error_nxt = ST_LARGE;
                step_nxt = SX_DONE;
              end else begin
                width_nxt = g_v16;
                step_nxt  = SX_HEIGHT;
              end
            end
            default: begin
              if (g_big) begin
                if (error_r == ST_OK) error_nxt = ST_LARGE;
                step_nxt = SX_DONE;
              end else begin
                height_nxt = g_v16;
                if (width_r == 16'd0 || g_v16 == 16'd0) begin
                  if (error_r == ST_OK) error_nxt = ST_ZERO;
                end
                step_nxt = SX_DONE;
              end
            end
          endcase
        end
      end
      CS_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_now;
          out_width_nxt  = (status_now == ST_OK) ? width_r : 16'd0;
          out_height_nxt = (status_now == ST_OK) ? height_r : 16'd0;
          state_nxt      = CS_IDLE;
          step_nxt       = SX_VPS;
          byte_index_nxt = 2'd0;
          zero_run_nxt   = 2'd0;
          field_cnt_nxt  = 7'd0;
          sub_count_nxt  = 3'd0;
          sub_flags_nxt  = 16'd0;
          sub_idx_nxt    = 3'd0;
          g_zeros_nxt    = 6'd0;
          g_value_nxt    = 33'd0;
          chroma_nxt     = 2'd0;
          width_nxt      = 16'd0;
          height_nxt     = 16'd0;
          error_nxt      = ST_OK;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CS_IDLE;
      step_r       <= SX_VPS;
      bit_cnt_r    <= 3'd0;
      last_r       <= 1'b0;
      byte_index_r <= 2'd0;
      zero_run_r   <= 2'd0;
      field_cnt_r  <= 7'd0;
      sub_count_r  <= 3'd0;
      sub_flags_r  <= 16'd0;
      sub_idx_r    <= 3'd0;
      g_zeros_r    <= 6'd0;
      g_value_r    <= 33'd0;
      chroma_r     <= 2'd0;
      width_r      <= 16'd0;
      height_r     <= 16'd0;
      error_r      <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      last_r       <= last_nxt;
      byte_index_r <= byte_index_nxt;
      zero_run_r   <= zero_run_nxt;
      field_cnt_r  <= field_cnt_nxt;
      sub_count_r  <= sub_count_nxt;
      sub_flags_r  <= sub_flags_nxt;
      sub_idx_r    <= sub_idx_nxt;
      g_zeros_r    <= g_zeros_nxt;
      g_value_r    <= g_value_nxt;
      chroma_r     <= chroma_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      error_r      <= error_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r      <= shift_nxt;
    out_status_r <= out_status_nxt;
    out_width_r  <= out_width_nxt;
    out_height_r <= out_height_nxt;
  end

  `HSPS_ASSERT(a_ok_size, clk, rst_n, out_valid && out_status == ST_OK |-> out_luma_width != 16'd0 && out_luma_height != 16'd0, "ok result carries a zero size")
  `HSPS_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_luma_width == 16'd0 && out_luma_height == 16'd0, "error result carries a size")
  `HSPS_ASSERT(a_sub_idx, clk, rst_n, step_r == SX_SUBPROF || step_r == SX_SUBLEVEL |-> sub_idx_r < sub_count_r, "sub-layer index beyond count")
  `HSPS_ASSERT(a_golomb, clk, rst_n, g_value_r != 33'd0 |-> g_zeros_r != 6'd0, "golomb suffix with no bits left")
  `HSPS_ASSERT_NEXT(a_finish, clk, rst_n, state_r == CS_FINISH && (!out_valid_r || out_ready), out_valid && state_r == CS_IDLE && byte_index_r == 2'd0, "finish did not post result and rearm")

endmodule
